### design/itar_pkg.sv
// Shared types, constants and tables for the tilt angle and turn rate block.
// Used by every module of the block and by its checker.
`default_nettype none

package itar_pkg;

    // Default number of CORDIC rotations and the length of the arctangent table
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // Datapath widths
    localparam int AXIS_W  = 35;   // corrected axis, 16 fraction bits
    localparam int CORD_W  = 37;   // CORDIC x and y, room for gain and pre-rotation
    localparam int ANGLE_W = 25;   // angle accumulator in 2^-15 degree
    localparam int DIFF_W  = 21;   // 16 * raw gyro minus zero offset
    localparam int RATE_W  = 28;   // rate difference times 125 plus rounding

    // Angle constants in 2^-15 degree and in 1/128 degree
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 25'sd2949120;
    localparam logic signed [16:0]        ANGLE_LIMIT  = 17'sd23040;

    // Rate saturation bounds
    localparam logic signed [16:0] RATE_MAX = 17'sd32767;
    localparam logic signed [16:0] RATE_MIN = -17'sd32768;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam logic [2:0] REG_GAIN_X    = 3'd0;
    localparam logic [2:0] REG_OFFSET_X  = 3'd1;
    localparam logic [2:0] REG_GAIN_Y    = 3'd2;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd3;
    localparam logic [2:0] REG_GYRO_ZERO = 3'd4;

    // Register reset values
    localparam logic signed [17:0] GAIN_X_RST    = 18'sd65589;
    localparam logic signed [19:0] OFFSET_X_RST  = -20'sd178;
    localparam logic signed [17:0] GAIN_Y_RST    = 18'sd65624;
    localparam logic signed [19:0] OFFSET_Y_RST  = -20'sd2743;
    localparam logic signed [19:0] GYRO_ZERO_RST = -20'sd4262;

    // atan(2^-i) in 2^-15 degree, rounded
    localparam logic [20:0] ATAN_TABLE [ATAN_LEN] = '{
        21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
        21'd29333,   21'd14667,  21'd7334,   21'd3667,   21'd1833,   21'd917,
        21'd458,     21'd229,    21'd115,    21'd57,     21'd29,     21'd14,
        21'd7,       21'd4,      21'd2,      21'd1,      21'd0,      21'd0
    };

    // One raw sample request
    typedef struct packed {
        logic signed [15:0] acc_x_raw;
        logic signed [15:0] acc_y_raw;
        logic signed [15:0] gyro_z_raw;
    } itar_sample_t;

    // One result request
    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] turn_rate;
    } itar_result_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [17:0] gain_x;
        logic signed [19:0] offset_x;
        logic signed [17:0] gain_y;
        logic signed [19:0] offset_y;
        logic signed [19:0] gyro_zero;
    } itar_cfg_t;

    // Classified request held in the queue: pre-rotated vector, start angle,
    // null-vector flag and the finished rate
    typedef struct packed {
        logic signed [CORD_W-1:0]  x;
        logic signed [CORD_W-1:0]  y;
        logic signed [ANGLE_W-1:0] z;
        logic                      null_vec;
        logic signed [15:0]        rate;
    } itar_item_t;

endpackage

`default_nettype wire

### design/itar_regs.sv
// Configuration registers behind the APB-style port.
// Depends on itar_pkg for register codes, reset values and the config struct.
`default_nettype none

module itar_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [itar_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [itar_pkg::PDATA_W-1:0]   pwdata,
    output logic      [itar_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output itar_pkg::itar_cfg_t                 cfg
);
    import itar_pkg::*;

    itar_cfg_t  cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register in the access cycle; drop unknown addresses
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x    <= GAIN_X_RST;
            cfg_reg.offset_x  <= OFFSET_X_RST;
            cfg_reg.gain_y    <= GAIN_Y_RST;
            cfg_reg.offset_y  <= OFFSET_Y_RST;
            cfg_reg.gyro_zero <= GYRO_ZERO_RST;
        end
        else if (wr_en)
        begin
            case (index)
                REG_GAIN_X:    cfg_reg.gain_x    <= pwdata[17:0];
                REG_OFFSET_X:  cfg_reg.offset_x  <= pwdata[19:0];
                REG_GAIN_Y:    cfg_reg.gain_y    <= pwdata[17:0];
                REG_OFFSET_Y:  cfg_reg.offset_y  <= pwdata[19:0];
                REG_GYRO_ZERO: cfg_reg.gyro_zero <= pwdata[19:0];
                default:       ;
            endcase
        end
    end

    // Return the addressed register, sign-extended
    always_comb
    begin
        case (index)
            REG_GAIN_X:    prdata = {{14{cfg_reg.gain_x[17]}}, cfg_reg.gain_x};
            REG_OFFSET_X:  prdata = {{12{cfg_reg.offset_x[19]}}, cfg_reg.offset_x};
            REG_GAIN_Y:    prdata = {{14{cfg_reg.gain_y[17]}}, cfg_reg.gain_y};
            REG_OFFSET_Y:  prdata = {{12{cfg_reg.offset_y[19]}}, cfg_reg.offset_y};
            REG_GYRO_ZERO: prdata = {{12{cfg_reg.gyro_zero[19]}}, cfg_reg.gyro_zero};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### design/itar_front.sv
// Front end: takes raw samples, applies gain and offset, works out the rate
// and pre-rotates the vector into the right half-plane. Depends on itar_pkg.
`default_nettype none

module itar_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire itar_pkg::itar_cfg_t   cfg,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire itar_pkg::itar_sample_t sample,
    output logic                       push,
    output itar_pkg::itar_item_t       push_item,
    input  wire logic                  queue_full
);
    import itar_pkg::*;

    logic                     s1_valid_reg;
    logic signed [33:0]       prod_x_reg;
    logic signed [33:0]       prod_y_reg;
    logic signed [DIFF_W-1:0] gdiff_reg;
    logic                     s2_valid_reg;
    itar_item_t               item_reg;
    itar_item_t               item_next;
    logic                     advance;

    logic signed [AXIS_W-1:0] cx;
    logic signed [AXIS_W-1:0] cy;
    logic signed [CORD_W-1:0] px;
    logic signed [CORD_W-1:0] py;
    logic signed [RATE_W-1:0] gd_ext;
    logic signed [RATE_W-1:0] rate_sum;
    logic signed [16:0]       rate_q;

    // Advance both stages together unless the finished request cannot leave
    assign advance      = !s2_valid_reg || !queue_full;
    assign sample_stall = !advance;
    assign push         = s2_valid_reg && !queue_full;
    assign push_item    = item_reg;

    // Classify: correct both axes, turn into the right half-plane, finish the rate
    always_comb
    begin
        cx = {prod_x_reg[33], prod_x_reg}
           + {{3{cfg.offset_x[19]}}, cfg.offset_x, 12'b0};
        cy = {prod_y_reg[33], prod_y_reg}
           + {{3{cfg.offset_y[19]}}, cfg.offset_y, 12'b0};
        px = {{(CORD_W-AXIS_W){cy[AXIS_W-1]}}, cy};
        py = {{(CORD_W-AXIS_W){cx[AXIS_W-1]}}, cx};

        item_next.null_vec = (cx == '0) && (cy == '0);
        if (px < 0)
        begin
            if (py >= 0)
            begin
                item_next.x = py;
                item_next.y = -px;
                item_next.z = QUARTER_TURN;
            end
            else
            begin
                item_next.x = -py;
                item_next.y = px;
                item_next.z = -QUARTER_TURN;
            end
        end
        else
        begin
            item_next.x = px;
            item_next.y = py;
            item_next.z = '0;
        end

        // times 125 as 128 - 4 + 1, then round half up and scale by 2^-11
        gd_ext   = {{(RATE_W-DIFF_W){gdiff_reg[DIFF_W-1]}}, gdiff_reg};
        rate_sum = (gd_ext <<< 7) - (gd_ext <<< 2) + gd_ext + 28'sd1024;
        rate_q   = rate_sum[RATE_W-1:11];
        if (rate_q > RATE_MAX)
            item_next.rate = RATE_MAX[15:0];
        else if (rate_q < RATE_MIN)
            item_next.rate = RATE_MIN[15:0];
        else
            item_next.rate = rate_q[15:0];
    end

    // Hold valid flags per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= sample_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Register products, then the classified request
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_x_reg <= cfg.gain_x * sample.acc_x_raw;
            prod_y_reg <= cfg.gain_y * sample.acc_y_raw;
            gdiff_reg  <= {sample.gyro_z_raw[15], sample.gyro_z_raw, 4'b0}
                        - {cfg.gyro_zero[19], cfg.gyro_zero};
            item_reg   <= item_next;
        end
    end

endmodule

`default_nettype wire

### design/itar_queue.sv
// Short request queue between the front end and the CORDIC back end.
// Depends on itar_pkg for the item type and the depth.
`default_nettype none

module itar_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire itar_pkg::itar_item_t push_item,
    output logic                      full,
    input  wire logic                 pop,
    output itar_pkg::itar_item_t      head_item,
    output logic                      empty
);
    import itar_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    itar_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### design/itar_back.sv
// Back end: pipelined CORDIC vectoring, one rotation per stage, then rounding,
// clamping and the output register. Depends on itar_pkg.
`default_nettype none

module itar_back #(
    parameter int CORDIC_STEPS = itar_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire itar_pkg::itar_item_t head_item,
    input  wire logic                 empty,
    output logic                      pop,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output itar_pkg::itar_result_t    result
);
    import itar_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    logic signed [CORD_W-1:0]  x_reg    [STEPS+1];
    logic signed [CORD_W-1:0]  y_reg    [STEPS+1];
    logic signed [ANGLE_W-1:0] z_reg    [STEPS+1];
    logic                      null_reg [STEPS+1];
    logic signed [15:0]        rate_reg [STEPS+1];
    logic [STEPS:0]            vld_reg;
    logic                      advance;
    logic                      result_valid_reg;
    itar_result_t              result_reg;
    itar_result_t              result_next;
    logic signed [ANGLE_W-1:0] z_round;
    logic signed [16:0]        angle_q;

    // Move the whole pipe unless a finished result is held back
    assign advance      = !result_valid_reg || !result_stall;
    assign pop          = advance && !empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Load the head of the queue into the first stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= head_item.x;
            y_reg[0]    <= head_item.y;
            z_reg[0]    <= head_item.z;
            null_reg[0] <= head_item.null_vec;
            rate_reg[0] <= head_item.rate;
        end
    end

    // One rotation per stage, driving y towards zero
    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        logic signed [ANGLE_W-1:0] step_angle;
        assign step_angle = {{(ANGLE_W-21){1'b0}}, ATAN_TABLE[i]};

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + step_angle;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - step_angle;
                end
                null_reg[i+1] <= null_reg[i];
                rate_reg[i+1] <= rate_reg[i];
            end
        end
    end

    // Round to 1/128 degree, half up, then clamp; a null vector gives zero
    always_comb
    begin
        z_round = z_reg[STEPS] + 25'sd128;
        angle_q = z_round[ANGLE_W-1:8];
        if (null_reg[STEPS])
            result_next.tilt_angle = '0;
        else if (angle_q > ANGLE_LIMIT)
            result_next.tilt_angle = ANGLE_LIMIT[15:0];
        else if (angle_q < -ANGLE_LIMIT)
            result_next.tilt_angle = 16'(-ANGLE_LIMIT);
        else
            result_next.tilt_angle = angle_q[15:0];
        result_next.turn_rate = rate_reg[STEPS];
    end

    // Shift valid flags along the pipe into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg          <= {vld_reg[STEPS-1:0], !empty};
            result_valid_reg <= vld_reg[STEPS];
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

### design/imu_tilt_angle_and_rate.sv
// Top level of the tilt angle and turn rate block: registers, front end,
// queue and CORDIC back end. Depends on itar_pkg and the itar_* modules.
`default_nettype none

// Each raw sample request gives one result: the tilt angle atan2 of the
// corrected X over the corrected Y axis in 1/128 degree, and the gyro Z rate
// in 1/128 deg/s, saturated to 16 bits. A new sample is taken every clock
// cycle while sample_stall is low; the CORDIC back end has one register stage
// per rotation (CORDIC_STEPS capped at 24). Each sample passes through the
// two front stages, the queue, the load stage of the back end, the rotation
// stages and the output register. A four-deep queue between the front end and
// the back end absorbs short stalls on the result side.
// Registers sit at byte address 4*i and may only be written while no request
// is in flight.
module imu_tilt_angle_and_rate #(
    parameter int CORDIC_STEPS = itar_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire itar_pkg::itar_sample_t         sample,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output itar_pkg::itar_result_t              result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [itar_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [itar_pkg::PDATA_W-1:0]   pwdata,
    output logic      [itar_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);
    import itar_pkg::*;

    itar_cfg_t  cfg;
    logic       push;
    itar_item_t push_item;
    logic       queue_full;
    logic       pop;
    itar_item_t head_item;
    logic       queue_empty;

    itar_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    itar_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    itar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty)
    );

    itar_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .empty        (queue_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### design/itar_checker.sv
// Port-level checks on the tilt angle and turn rate block, bound to the top.
// Depends on itar_pkg for types and constants.
`default_nettype none

module itar_port_checks (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         sample_valid,
    input wire logic                         sample_stall,
    input wire itar_pkg::itar_sample_t       sample,
    input wire logic                         result_valid,
    input wire logic                         result_stall,
    input wire itar_pkg::itar_result_t       result,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [itar_pkg::PADDR_W-1:0] paddr,
    input wire logic [itar_pkg::PDATA_W-1:0] pwdata,
    input wire logic [itar_pkg::PDATA_W-1:0] prdata,
    input wire logic                         pready
);
    import itar_pkg::*;

    localparam logic [PADDR_W-1:0] GYRO_ADDR = {REG_GYRO_ZERO, 2'b00};

    // Hold a stalled result
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    // Angle stays within the clamp
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(result.tilt_angle) <= $signed(ANGLE_LIMIT[15:0])
                       && $signed(result.tilt_angle) >= -$signed(ANGLE_LIMIT[15:0])))
        else $error("tilt angle out of range");

    // Read back of the gyro zero offset returns what was just written
    a_gyro_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == GYRO_ADDR)
        ##1 (psel && !pwrite && paddr == GYRO_ADDR)
        |-> prdata == {{12{$past(pwdata[19])}}, $past(pwdata[19:0])})
        else $error("gyro zero read back mismatch");

endmodule

bind imu_tilt_angle_and_rate itar_port_checks u_checker (.*);

`default_nettype wire
